[hdl/qcli_pkg.sv]
// shared types and widths for the quad cell / line intersection block
// no dependencies; imported by every module of the block
package qcli_pkg;

    localparam int COORD_W = 32;            // signed q16.16 coordinate
    localparam int NC      = 4;             // corners of a cell
    localparam int DIFF_W  = COORD_W + 1;   // coordinate difference
    localparam int MB_W    = 2 * DIFF_W;    // wide multiplier operand
    localparam int LO_W    = DIFF_W;        // low slice of the wide operand
    localparam int HI_W    = MB_W - LO_W;   // high slice of the wide operand
    localparam int P_W     = DIFF_W + MB_W; // multiplier product
    localparam int DET_W   = MB_W + 1;      // determinant, signed
    localparam int DM_W    = MB_W;          // determinant magnitude
    localparam int NUM_W   = P_W + 1;       // cramer numerator, signed
    localparam int QB      = COORD_W + 2;   // quotient bits kept
    localparam int Q_W     = QB + 1;        // signed floored quotient
    localparam int REM_W   = DM_W + 1;      // divider partial remainder
    localparam int CNT_W   = 3;
    localparam int THR_W   = 32;
    localparam int MUL_LAT = 2;
    localparam int DIV_LAT = QB + 3;
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);

    typedef struct packed {
        logic signed [COORD_W-1:0] v0_x;
        logic signed [COORD_W-1:0] v0_y;
        logic signed [COORD_W-1:0] v1_x;
        logic signed [COORD_W-1:0] v1_y;
        logic signed [COORD_W-1:0] v2_x;
        logic signed [COORD_W-1:0] v2_y;
        logic signed [COORD_W-1:0] v3_x;
        logic signed [COORD_W-1:0] v3_y;
        logic signed [COORD_W-1:0] line_p_x;
        logic signed [COORD_W-1:0] line_p_y;
        logic signed [COORD_W-1:0] line_q_x;
        logic signed [COORD_W-1:0] line_q_y;
    } cell_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] hit0_x;
        logic signed [COORD_W-1:0] hit0_y;
        logic signed [COORD_W-1:0] hit1_x;
        logic signed [COORD_W-1:0] hit1_y;
        logic [CNT_W-1:0]          hit_count;
    } hits_t;

    // per-beat control that rides alongside the arithmetic
    typedef struct packed {
        logic                      vld;
        logic signed [COORD_W-1:0] xmin;
        logic signed [COORD_W-1:0] xmax;
        logic signed [COORD_W-1:0] ymin;
        logic signed [COORD_W-1:0] ymax;
        logic [NC-1:0]             skip;
    } side_t;

    typedef struct packed {
        logic [NC-1:0][DIFF_W-1:0] a1;
        logic [NC-1:0][DIFF_W-1:0] b1;
        logic [DIFF_W-1:0]         a2;
        logic [DIFF_W-1:0]         b2;
    } coef_t;

    typedef logic [NC-1:0][DET_W-1:0] det_vec_t;

endpackage

[hdl/qcli_mul.sv]
// two-stage signed multiplier, 33 x 66 bits, wide operand split in two slices
// depends on qcli_pkg
module qcli_mul (
    input  logic                           clk,
    input  logic                           en,
    input  logic signed [qcli_pkg::DIFF_W-1:0] a,
    input  logic signed [qcli_pkg::MB_W-1:0]   b,
    output logic signed [qcli_pkg::P_W-1:0]    p
);
    import qcli_pkg::*;

    logic signed [DIFF_W+LO_W:0]   pl_next, pl_reg;
    logic signed [DIFF_W+HI_W-1:0] ph_next, ph_reg;
    logic signed [P_W-1:0]         p_next, p_reg;

    // low slice is unsigned, high slice carries the sign
    assign pl_next = a * $signed({1'b0, b[LO_W-1:0]});
    assign ph_next = a * $signed(b[MB_W-1:LO_W]);
    assign p_next  = $signed({ph_reg, {LO_W{1'b0}}}) + P_W'(pl_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pl_reg <= pl_next;
            ph_reg <= ph_next;
            p_reg  <= p_next;
        end
    end

    assign p = p_reg;

endmodule

[hdl/qcli_div.sv]
// pipelined restoring divider, one quotient bit per stage, floored signed result
// depends on qcli_pkg
module qcli_div (
    input  logic                            clk,
    input  logic                            en,
    input  logic signed [qcli_pkg::NUM_W-1:0] num,
    input  logic signed [qcli_pkg::DET_W-1:0] den,
    output logic signed [qcli_pkg::Q_W-1:0]   quo,
    output logic                            frac,
    output logic                            ovf
);
    import qcli_pkg::*;

    logic [NUM_W-1:0] nmag_reg;
    logic [DM_W-1:0]  dmag_reg;
    logic             negp_reg;

    logic [REM_W-1:0] r_reg   [0:QB];
    logic [QB-1:0]    q_reg   [0:QB];
    logic [QB-1:0]    nlo_reg [0:QB];
    logic [DM_W-1:0]  d_reg   [0:QB];
    logic             neg_reg [0:QB];
    logic             ovf_reg [0:QB];

    logic signed [Q_W-1:0] quo_reg;
    logic                  frac_reg, ovf_out_reg;
    logic [Q_W-1:0]        qs;
    logic                  fr;

    // magnitudes and sign of the result
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nmag_reg <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
            dmag_reg <= den[DET_W-1] ? DM_W'(-den) : DM_W'(den);
            negp_reg <= num[NUM_W-1] ^ den[DET_W-1];
        end
    end

    // quotient too large for the kept bits lies outside any box
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0]   <= REM_W'(nmag_reg[NUM_W-1:QB]);
            q_reg[0]   <= '0;
            nlo_reg[0] <= nmag_reg[QB-1:0];
            d_reg[0]   <= dmag_reg;
            neg_reg[0] <= negp_reg;
            ovf_reg[0] <= nmag_reg >= {dmag_reg, {QB{1'b0}}};
        end
    end

    for (genvar k = 0; k < QB; k++)
    begin : g_step
        logic [REM_W-1:0] rs;
        logic             ge;

        assign rs = {r_reg[k][REM_W-2:0], nlo_reg[k][QB-1-k]};
        assign ge = rs >= REM_W'(d_reg[k]);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[k+1]   <= ge ? rs - REM_W'(d_reg[k]) : rs;
                q_reg[k+1]   <= {q_reg[k][QB-2:0], ge};
                nlo_reg[k+1] <= nlo_reg[k];
                d_reg[k+1]   <= d_reg[k];
                neg_reg[k+1] <= neg_reg[k];
                ovf_reg[k+1] <= ovf_reg[k];
            end
        end
    end

    // floor: -q when exact, ~q (= -q-1) when a remainder is left
    assign qs = {1'b0, q_reg[QB]};
    assign fr = |r_reg[QB];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_reg     <= $signed(neg_reg[QB] ? (fr ? ~qs : -qs) : qs);
            frac_reg    <= fr;
            ovf_out_reg <= ovf_reg[QB];
        end
    end

    assign quo  = quo_reg;
    assign frac = frac_reg;
    assign ovf  = ovf_out_reg;

endmodule

[hdl/quad_cell_line_intersect.sv]
// top level: quad cell / line intersection pipeline with output register
// depends on qcli_pkg, qcli_mul, qcli_div
//
// usage
//   cell channel (cell_valid/cell_ready/cell_data) takes one beat per cell:
//   four vertices and two points on the line, all signed q16.16
//   res channel (res_valid/res_ready/res_data) gives one beat per cell: the
//   first two in-box intersections in edge order and the hit count
//   cfg channel writes det_threshold; it is always ready
// throughput: one cell per cycle, back to back, unless a held result stalls the pipe
// pipeline: 1 input stage, 1 edge setup stage, two 2-stage multiplier
//   banks with a sum stage after each, a 37-stage bit-per-stage divider
//   and the output register
// reset: clears every valid bit and sets det_threshold to 1
// stall: all stages move on one enable; when a result sits in the output
//   register and res_ready is low the whole pipe holds, nothing is lost;
//   bubbles in flight do not block, only the output register does
module quad_cell_line_intersect (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cell_valid,
    output logic                         cell_ready,
    input  qcli_pkg::cell_t              cell_data,
    output logic                         res_valid,
    input  logic                         res_ready,
    output qcli_pkg::hits_t              res_data,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [qcli_pkg::THR_W-1:0]   cfg_data
);
    import qcli_pkg::*;

    logic adv;

    logic [THR_W-1:0] thr_reg;

    // input stage
    cell_t in_reg;
    logic  in_vld_reg;

    // edge setup stage
    logic signed [COORD_W-1:0] vx [NC];
    logic signed [COORD_W-1:0] vy [NC];
    logic signed [COORD_W-1:0] xmn, xmx, ymn, ymx;
    coef_t coef_next, coef1_reg;
    side_t side1_reg;
    logic signed [COORD_W-1:0] vx1_reg [NC];
    logic signed [COORD_W-1:0] vy1_reg [NC];
    logic signed [COORD_W-1:0] px1_reg, py1_reg;

    // first multiplier bank
    logic signed [P_W-1:0] pda [NC];
    logic signed [P_W-1:0] pdb [NC];
    logic signed [P_W-1:0] pcx [NC];
    logic signed [P_W-1:0] pcy [NC];
    logic signed [P_W-1:0] pex, pey;
    coef_t coef_dly [MUL_LAT];
    side_t side_dly1 [MUL_LAT];

    // determinant and constants stage
    det_vec_t det_next, det4_reg;
    logic [NC-1:0] skip_next;
    logic signed [MB_W-1:0] c1_next [NC];
    logic signed [MB_W-1:0] c1_reg [NC];
    logic signed [MB_W-1:0] c2_reg;
    coef_t coef4_reg;
    side_t side4_reg;

    // second multiplier bank
    logic signed [P_W-1:0] pxa [NC];
    logic signed [P_W-1:0] pxb [NC];
    logic signed [P_W-1:0] pya [NC];
    logic signed [P_W-1:0] pyb [NC];
    det_vec_t det_dly [MUL_LAT];
    side_t side_dly2 [MUL_LAT];

    // numerator stage
    logic signed [NUM_W-1:0] nx_reg [NC];
    logic signed [NUM_W-1:0] ny_reg [NC];
    det_vec_t det7_reg;
    side_t side7_reg;

    // dividers
    logic signed [Q_W-1:0] qx [NC];
    logic signed [Q_W-1:0] qy [NC];
    logic [NC-1:0] fx, fy, ox, oy;
    side_t side_dly3 [DIV_LAT];
    side_t side_f;

    // select and output
    logic [NC-1:0] hit;
    hits_t res_next, res_reg;
    logic res_vld_reg;
    logic signed [Q_W-1:0] xlo, xhi, ylo, yhi;

    // the output register is the only place that can hold the pipe
    assign adv        = !res_vld_reg || res_ready;
    assign cell_ready = adv;
    assign cfg_ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= THR_RESET;
        else if (cfg_valid)
            thr_reg <= cfg_data;
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (adv)
            in_vld_reg <= cell_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            in_reg <= cell_data;
    end

    // edge setup: differences and bounding box
    assign vx[0] = in_reg.v0_x;
    assign vy[0] = in_reg.v0_y;
    assign vx[1] = in_reg.v1_x;
    assign vy[1] = in_reg.v1_y;
    assign vx[2] = in_reg.v2_x;
    assign vy[2] = in_reg.v2_y;
    assign vx[3] = in_reg.v3_x;
    assign vy[3] = in_reg.v3_y;

    always_comb
    begin
        xmn = vx[0];
        xmx = vx[0];
        ymn = vy[0];
        ymx = vy[0];
        for (int i = 1; i < NC; i++)
        begin
            if (vx[i] < xmn) xmn = vx[i];
            if (vx[i] > xmx) xmx = vx[i];
            if (vy[i] < ymn) ymn = vy[i];
            if (vy[i] > ymx) ymx = vy[i];
        end
        for (int i = 0; i < NC; i++)
        begin
            coef_next.a1[i] = DIFF_W'(vy[(i+1)%NC]) - DIFF_W'(vy[i]);
            coef_next.b1[i] = DIFF_W'(vx[i]) - DIFF_W'(vx[(i+1)%NC]);
        end
        coef_next.a2 = DIFF_W'(in_reg.line_q_y) - DIFF_W'(in_reg.line_p_y);
        coef_next.b2 = DIFF_W'(in_reg.line_p_x) - DIFF_W'(in_reg.line_q_x);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            side1_reg <= '0;
        else if (adv)
            side1_reg <= '{vld: in_vld_reg, xmin: xmn, xmax: xmx, ymin: ymn, ymax: ymx,
                           skip: '0};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            coef1_reg <= coef_next;
            vx1_reg   <= vx;
            vy1_reg   <= vy;
            px1_reg   <= in_reg.line_p_x;
            py1_reg   <= in_reg.line_p_y;
        end
    end

    // first bank: determinant terms and edge constants
    for (genvar i = 0; i < NC; i++)
    begin : g_mul1
        qcli_mul u_det_a (.clk(clk), .en(adv), .a($signed(coef1_reg.a1[i])),
                          .b(MB_W'($signed(coef1_reg.b2))), .p(pda[i]));
        qcli_mul u_det_b (.clk(clk), .en(adv), .a($signed(coef1_reg.a2)),
                          .b(MB_W'($signed(coef1_reg.b1[i]))), .p(pdb[i]));
        qcli_mul u_c1_x  (.clk(clk), .en(adv), .a($signed(coef1_reg.a1[i])),
                          .b(MB_W'(vx1_reg[i])), .p(pcx[i]));
        qcli_mul u_c1_y  (.clk(clk), .en(adv), .a($signed(coef1_reg.b1[i])),
                          .b(MB_W'(vy1_reg[i])), .p(pcy[i]));
    end

    qcli_mul u_c2_x (.clk(clk), .en(adv), .a($signed(coef1_reg.a2)),
                     .b(MB_W'(px1_reg)), .p(pex));
    qcli_mul u_c2_y (.clk(clk), .en(adv), .a($signed(coef1_reg.b2)),
                     .b(MB_W'(py1_reg)), .p(pey));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MUL_LAT; k++)
                side_dly1[k] <= '0;
        end
        else if (adv)
        begin
            side_dly1[0] <= side1_reg;
            for (int k = 1; k < MUL_LAT; k++)
                side_dly1[k] <= side_dly1[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            coef_dly[0] <= coef1_reg;
            for (int k = 1; k < MUL_LAT; k++)
                coef_dly[k] <= coef_dly[k-1];
        end
    end

    // determinant, threshold test, edge constants c1 and c2
    always_comb
    begin
        logic signed [DET_W-1:0] d;
        logic [DET_W-1:0]        dm;
        for (int i = 0; i < NC; i++)
        begin
            d  = DET_W'(pda[i] - pdb[i]);
            dm = d[DET_W-1] ? DET_W'(-d) : DET_W'(d);
            det_next[i]  = d;
            skip_next[i] = (d == '0) || (dm < DET_W'(thr_reg));
            c1_next[i]   = MB_W'(pcx[i] + pcy[i]);
        end
    end

    // box and valid bit move on, skip flags are filled in here
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            side4_reg <= '0;
        else if (adv)
            side4_reg <= '{vld: side_dly1[MUL_LAT-1].vld,
                           xmin: side_dly1[MUL_LAT-1].xmin,
                           xmax: side_dly1[MUL_LAT-1].xmax,
                           ymin: side_dly1[MUL_LAT-1].ymin,
                           ymax: side_dly1[MUL_LAT-1].ymax,
                           skip: skip_next};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            det4_reg  <= det_next;
            c1_reg    <= c1_next;
            c2_reg    <= MB_W'(pex + pey);
            coef4_reg <= coef_dly[MUL_LAT-1];
        end
    end

    // second bank: cramer numerator terms
    for (genvar i = 0; i < NC; i++)
    begin : g_mul2
        qcli_mul u_nx_a (.clk(clk), .en(adv), .a($signed(coef4_reg.b2)),
                         .b(c1_reg[i]), .p(pxa[i]));
        qcli_mul u_nx_b (.clk(clk), .en(adv), .a($signed(coef4_reg.b1[i])),
                         .b(c2_reg), .p(pxb[i]));
        qcli_mul u_ny_a (.clk(clk), .en(adv), .a($signed(coef4_reg.a1[i])),
                         .b(c2_reg), .p(pya[i]));
        qcli_mul u_ny_b (.clk(clk), .en(adv), .a($signed(coef4_reg.a2)),
                         .b(c1_reg[i]), .p(pyb[i]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MUL_LAT; k++)
                side_dly2[k] <= '0;
            side7_reg <= '0;
        end
        else if (adv)
        begin
            side_dly2[0] <= side4_reg;
            for (int k = 1; k < MUL_LAT; k++)
                side_dly2[k] <= side_dly2[k-1];
            side7_reg <= side_dly2[MUL_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            det_dly[0] <= det4_reg;
            for (int k = 1; k < MUL_LAT; k++)
                det_dly[k] <= det_dly[k-1];
            det7_reg <= det_dly[MUL_LAT-1];
            for (int i = 0; i < NC; i++)
            begin
                nx_reg[i] <= NUM_W'(pxa[i]) - NUM_W'(pxb[i]);
                ny_reg[i] <= NUM_W'(pya[i]) - NUM_W'(pyb[i]);
            end
        end
    end

    // one divider per edge and axis
    for (genvar i = 0; i < NC; i++)
    begin : g_div
        qcli_div u_div_x (.clk(clk), .en(adv), .num(nx_reg[i]),
                          .den($signed(det7_reg[i])),
                          .quo(qx[i]), .frac(fx[i]), .ovf(ox[i]));
        qcli_div u_div_y (.clk(clk), .en(adv), .num(ny_reg[i]),
                          .den($signed(det7_reg[i])),
                          .quo(qy[i]), .frac(fy[i]), .ovf(oy[i]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DIV_LAT; k++)
                side_dly3[k] <= '0;
        end
        else if (adv)
        begin
            side_dly3[0] <= side7_reg;
            for (int k = 1; k < DIV_LAT; k++)
                side_dly3[k] <= side_dly3[k-1];
        end
    end

    assign side_f = side_dly3[DIV_LAT-1];
    assign xlo    = Q_W'(side_f.xmin);
    assign xhi    = Q_W'(side_f.xmax);
    assign ylo    = Q_W'(side_f.ymin);
    assign yhi    = Q_W'(side_f.ymax);

    // box test on the exact quotient: floor plus remainder flag
    always_comb
    begin
        logic [CNT_W-1:0] cnt;
        cnt      = '0;
        res_next = '0;
        for (int i = 0; i < NC; i++)
        begin
            hit[i] = !side_f.skip[i] && !ox[i] && !oy[i]
                     && (qx[i] >= xlo) && ((qx[i] < xhi) || ((qx[i] == xhi) && !fx[i]))
                     && (qy[i] >= ylo) && ((qy[i] < yhi) || ((qy[i] == yhi) && !fy[i]));
            if (hit[i])
            begin
                if (cnt == CNT_W'(0))
                begin
                    res_next.hit0_x = COORD_W'(qx[i]);
                    res_next.hit0_y = COORD_W'(qy[i]);
                end
                else if (cnt == CNT_W'(1))
                begin
                    res_next.hit1_x = COORD_W'(qx[i]);
                    res_next.hit1_y = COORD_W'(qy[i]);
                end
                cnt = cnt + CNT_W'(1);
            end
        end
        res_next.hit_count = cnt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_vld_reg <= 1'b0;
        else if (adv)
            res_vld_reg <= side_f.vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            res_reg <= res_next;
    end

    assign res_valid = res_vld_reg;
    assign res_data  = res_reg;

    // at most one hit per edge
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_data.hit_count <= CNT_W'(NC)))
        else $error("hit count above corner count");

    // no hits leaves the first slot zero
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res_data.hit_count == CNT_W'(0))) |->
        ((res_data.hit0_x == '0) && (res_data.hit0_y == '0)))
        else $error("first slot filled without a hit");

    // fewer than two hits leaves the second slot zero
    a_second_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res_data.hit_count < CNT_W'(2))) |->
        ((res_data.hit1_x == '0) && (res_data.hit1_y == '0)))
        else $error("second slot filled with fewer than two hits");

    // a config beat lands in the threshold register
    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |=> (thr_reg == $past(cfg_data)))
        else $error("threshold write lost");

endmodule

[tb/qcli_checker.sv]
// checker for the quad cell / line intersection block: predicts each result
// from the accepted cell beats and compares it with the result beats
// depends on qcli_pkg
`timescale 1ns / 1ps

module qcli_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cell_valid,
    input  logic                       cell_ready,
    input  qcli_pkg::cell_t            cell_data,
    input  logic                       res_valid,
    input  logic                       res_ready,
    input  qcli_pkg::hits_t            res_data,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [qcli_pkg::THR_W-1:0] cfg_data,
    output int                         fail_count,
    output int                         pending
);
    import qcli_pkg::*;

    typedef logic signed [159:0] wide_t;

    logic [THR_W-1:0] det_thr;
    hits_t            expected_hits[$];

    // floored quotient; frac flags a nonzero remainder
    function automatic wide_t floor_quot(wide_t n, wide_t d, output bit frac);
        wide_t q;
        wide_t r;
        q = n / d;
        r = n % d;
        frac = (r != 0);
        if (frac && ((n < 0) != (d < 0)))
            q = q - 1;
        return q;
    endfunction

    function automatic bit in_box(wide_t q, bit frac, wide_t lo, wide_t hi);
        if (q < lo || q > hi)
            return 0;
        if (q == hi && frac)
            return 0;
        return 1;
    endfunction

    function automatic hits_t cramer_hits(cell_t c, logic [THR_W-1:0] thr);
        wide_t vx[NC];
        wide_t vy[NC];
        wide_t xmin, xmax, ymin, ymax, xp, yp, xq, yq;
        wide_t a1, b1, a2, b2, c1, c2, det, adet, thr_w, qx, qy;
        bit fx, fy;
        int j;
        int count;
        hits_t h;
        vx[0] = wide_t'(c.v0_x); vy[0] = wide_t'(c.v0_y);
        vx[1] = wide_t'(c.v1_x); vy[1] = wide_t'(c.v1_y);
        vx[2] = wide_t'(c.v2_x); vy[2] = wide_t'(c.v2_y);
        vx[3] = wide_t'(c.v3_x); vy[3] = wide_t'(c.v3_y);
        xp = wide_t'(c.line_p_x); yp = wide_t'(c.line_p_y);
        xq = wide_t'(c.line_q_x); yq = wide_t'(c.line_q_y);
        h = '0;
        count = 0;
        xmin = vx[0]; xmax = vx[0]; ymin = vy[0]; ymax = vy[0];
        for (int i = 1; i < NC; i++)
        begin
            if (vx[i] < xmin) xmin = vx[i];
            if (vx[i] > xmax) xmax = vx[i];
            if (vy[i] < ymin) ymin = vy[i];
            if (vy[i] > ymax) ymax = vy[i];
        end
        a2 = yq - yp;
        b2 = xp - xq;
        c2 = a2 * xp + b2 * yp;
        thr_w = $signed({128'b0, thr});
        for (int i = 0; i < NC; i++)
        begin
            j = (i + 1) % NC;
            a1 = vy[j] - vy[i];
            b1 = vx[i] - vx[j];
            det = a1 * b2 - a2 * b1;
            adet = (det < 0) ? -det : det;
            // zero det always skips, even with a zero threshold
            if (det == 0 || adet < thr_w)
                continue;
            c1 = a1 * vx[i] + b1 * vy[i];
            qx = floor_quot(b2 * c1 - b1 * c2, det, fx);
            qy = floor_quot(a1 * c2 - a2 * c1, det, fy);
            if (!in_box(qx, fx, xmin, xmax) || !in_box(qy, fy, ymin, ymax))
                continue;
            if (count == 0)
            begin
                h.hit0_x = qx[COORD_W-1:0];
                h.hit0_y = qy[COORD_W-1:0];
            end
            else if (count == 1)
            begin
                h.hit1_x = qx[COORD_W-1:0];
                h.hit1_y = qy[COORD_W-1:0];
            end
            count++;
        end
        h.hit_count = CNT_W'(count);
        return h;
    endfunction

    assign pending = expected_hits.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            det_thr <= THR_RESET;
            expected_hits.delete();
            fail_count <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                det_thr <= cfg_data;
            if (cell_valid && cell_ready)
                expected_hits.push_back(cramer_hits(cell_data, det_thr));
            if (res_valid && res_ready)
            begin
                if (expected_hits.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    hits_t e;
                    int bad;
                    e = expected_hits.pop_front();
                    bad = 0;
                    if (res_data.hit0_x !== e.hit0_x)
                    begin
                        $error("hit0_x expected %0d got %0d", e.hit0_x, res_data.hit0_x);
                        bad++;
                    end
                    if (res_data.hit0_y !== e.hit0_y)
                    begin
                        $error("hit0_y expected %0d got %0d", e.hit0_y, res_data.hit0_y);
                        bad++;
                    end
                    if (res_data.hit1_x !== e.hit1_x)
                    begin
                        $error("hit1_x expected %0d got %0d", e.hit1_x, res_data.hit1_x);
                        bad++;
                    end
                    if (res_data.hit1_y !== e.hit1_y)
                    begin
                        $error("hit1_y expected %0d got %0d", e.hit1_y, res_data.hit1_y);
                        bad++;
                    end
                    if (res_data.hit_count !== e.hit_count)
                    begin
                        $error("hit_count expected %0d got %0d", e.hit_count,
                               res_data.hit_count);
                        bad++;
                    end
                    fail_count <= fail_count + bad;
                end
            end
        end
    end

endmodule

[tb/tb_quad_cell_line_intersect.sv]
// testbench top for quad_cell_line_intersect: drives cell and config beats,
// stalls the result side, and reports the verdict
// depends on qcli_pkg, qcli_checker and the block itself
`timescale 1ns / 1ps

module tb_quad_cell_line_intersect;
    import qcli_pkg::*;

    localparam int ONE = 65536;     // 1.0 in q16.16
    localparam int DRAIN = 60;      // drain wait, longer than the pipeline latency

    logic             clk;
    logic             rst_n;
    logic             cell_valid;
    logic             cell_ready;
    cell_t            cell_data;
    logic             res_valid;
    logic             res_ready;
    hits_t            res_data;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [THR_W-1:0] cfg_data;
    int               fail_count;
    int               pending;

    // idle odds in percent, changed per phase
    int send_idle_pct;
    int recv_stall_pct;

    quad_cell_line_intersect u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cell_valid (cell_valid),
        .cell_ready (cell_ready),
        .cell_data  (cell_data),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_data   (res_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    qcli_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cell_valid (cell_valid),
        .cell_ready (cell_ready),
        .cell_data  (cell_data),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_data   (res_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result side: ready redrawn every falling edge
    initial
    begin
        res_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            res_ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // hard stop; the slowest legal run is far below this
    initial
    begin
        #2ms;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic cell_t make_cell(int x0, int y0, int x1, int y1, int x2, int y2,
                                        int x3, int y3, int px, int py, int qx, int qy);
        cell_t c;
        c.v0_x = x0; c.v0_y = y0; c.v1_x = x1; c.v1_y = y1;
        c.v2_x = x2; c.v2_y = y2; c.v3_x = x3; c.v3_y = y3;
        c.line_p_x = px; c.line_p_y = py; c.line_q_x = qx; c.line_q_y = qy;
        return c;
    endfunction

    // mostly a jittered quad with a line through it; some fully random
    // beats and some degenerate lines (p equal to q, or parallel to edge 0)
    function automatic cell_t random_cell();
        cell_t c;
        int cx, cy, s, sel, px, py;
        sel = $urandom_range(99);
        if (sel < 15)
        begin
            c = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            return c;
        end
        s = (sel < 85) ? $urandom_range(1 << 20, 1) : $urandom_range(8, 1);
        cx = int'($urandom_range(1 << 25)) - (1 << 24);
        cy = int'($urandom_range(1 << 25)) - (1 << 24);
        c.v0_x = cx - s + int'($urandom_range(s / 2)); c.v0_y = cy - s;
        c.v1_x = cx + s; c.v1_y = cy - s + int'($urandom_range(s / 2));
        c.v2_x = cx + s - int'($urandom_range(s / 2)); c.v2_y = cy + s;
        c.v3_x = cx - s; c.v3_y = cy + s - int'($urandom_range(s / 2));
        px = cx + int'($urandom_range(2 * s)) - s;
        py = cy + int'($urandom_range(2 * s)) - s;
        c.line_p_x = px;
        c.line_p_y = py;
        if (sel < 80)
        begin
            c.line_q_x = px + int'($urandom_range(2 * s)) - s;
            c.line_q_y = py + int'($urandom_range(2 * s)) - s;
        end
        else if (sel < 90)
        begin
            // along edge 0 direction
            c.line_q_x = px + (c.v1_x - c.v0_x);
            c.line_q_y = py + (c.v1_y - c.v0_y);
        end
        else
        begin
            c.line_q_x = px;
            c.line_q_y = py;
        end
        return c;
    endfunction

    // entered and left on a falling edge; valid stays up for back to back beats
    task automatic send_cell(cell_t c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cell_valid = 1'b0;
            @(negedge clk);
        end
        cell_valid = 1'b1;
        cell_data  = c;
        @(posedge clk);
        while (!cell_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // only while idle: every result back and the pipe drained
    task automatic write_threshold(logic [THR_W-1:0] value);
        cell_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    initial
    begin
        int waited;
        rst_n = 1'b0;
        cell_valid = 1'b0;
        cell_data = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed beats under the reset threshold
        send_idle_pct = 20;
        recv_stall_pct = 30;
        // all zero: zero determinant everywhere
        send_cell('0);
        // unit square, horizontal line through the middle: two hits
        send_cell(make_cell(0, 0, ONE, 0, ONE, ONE, 0, ONE, -ONE, ONE / 2, 2 * ONE, ONE / 2));
        // diagonal through two corners: four hits, extras dropped
        send_cell(make_cell(0, 0, ONE, 0, ONE, ONE, 0, ONE, 0, 0, ONE, ONE));
        // line well outside the box: out-of-box points skipped
        send_cell(make_cell(0, 0, ONE, 0, ONE, ONE, 0, ONE, 5 * ONE, 0, 5 * ONE, ONE));
        // line through only a corner, touching the box edge
        send_cell(make_cell(0, 0, ONE, 0, ONE, ONE, 0, ONE, -ONE, ONE, ONE, -ONE));
        // p equal to q: no line at all
        send_cell(make_cell(0, 0, ONE, 0, ONE, ONE, 0, ONE, 3, 3, 3, 3));
        // vertical line parallel to the left and right edges, crossing the top and bottom edges
        send_cell(make_cell(0, 0, ONE, 0, ONE, ONE, 0, ONE, ONE / 3, -5, ONE / 3, 7));
        // inexact quotients in negative space: floor rounding
        send_cell(make_cell(-3 * ONE, -3 * ONE, -1, -3 * ONE, -1, -1, -3 * ONE, -1,
                            -7, -ONE, -3 * ONE + 1, -2 * ONE - 3));
        send_cell(make_cell(-7, -7, 0, -7, 0, 0, -7, 0, -8, -1, 1, -6));
        // tiny determinant near the threshold of one
        send_cell(make_cell(0, 0, 1, 0, 1, 1, 0, 1, 0, 0, 1, 1));
        // coordinate extremes
        send_cell(make_cell(32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
                            32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
                            32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff));
        send_cell(make_cell(32'sh8000_0000, 0, 32'sh7fff_ffff, 0, 32'sh7fff_ffff, 1,
                            32'sh8000_0000, 1, 0, 32'sh8000_0000, 1, 32'sh7fff_ffff));
        send_cell({12{32'hffff_ffff}});
        send_cell({12{32'h8000_0000}});
        send_cell({12{32'h7fff_ffff}});
        send_cell({6{32'h5555_5555, 32'haaaa_aaaa}});
        // twisted quad
        send_cell(make_cell(0, 0, ONE, ONE, ONE, 0, 0, ONE, 0, ONE / 2, ONE, ONE / 2));

        // random phases, each under its own threshold, the last two with no idle or stall
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: write_threshold('0);
                1: write_threshold('1);
                2: write_threshold(THR_W'($urandom_range(1 << 24)));
                default: write_threshold(THR_RESET);
            endcase
            send_idle_pct  = (ph == 0) ? 6 : (ph == 1) ? 70 : 0;
            recv_stall_pct = (ph == 0) ? 70 : (ph == 1) ? 6 : 0;
            for (int n = 0; n < 100; n++)
                send_cell(random_cell());
        end
        cell_valid = 1'b0;

        // drain: wait for every result, then a little more for strays
        waited = 0;
        while (pending != 0 && waited < 100000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (DRAIN) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[quad_cell_line_intersect.f]
hdl/qcli_pkg.sv
hdl/qcli_mul.sv
hdl/qcli_div.sv
hdl/quad_cell_line_intersect.sv
tb/qcli_checker.sv
tb/tb_quad_cell_line_intersect.sv
